// ===== src/s5req_pkg.sv =====
package s5req_pkg;

    // Depth of the queue between the byte classifier and the parser
    localparam int QUEUE_DEPTH = 2;

    // Byte position counter width, counts up to a 255-byte name plus 6
    localparam int POS_W = 9;

    localparam logic [7:0] SOCKS_VERSION = 8'h05;
    localparam logic [7:0] RESERVED_BYTE = 8'h00;
    localparam logic [7:0] ATYP_IPV4     = 8'h01;
    localparam logic [7:0] ATYP_NAME     = 8'h03;

    // Byte positions inside a request
    localparam logic [POS_W-1:0] POS_VERSION   = POS_W'(0);
    localparam logic [POS_W-1:0] POS_COMMAND   = POS_W'(1);
    localparam logic [POS_W-1:0] POS_RESERVED  = POS_W'(2);
    localparam logic [POS_W-1:0] POS_ATYP      = POS_W'(3);
    localparam logic [POS_W-1:0] POS_ADDR      = POS_W'(4);
    localparam logic [POS_W-1:0] POS_IPV4_END  = POS_W'(7);
    localparam logic [POS_W-1:0] POS_IPV4_LAST = POS_W'(9);
    // last position of a name request is name length + 6
    localparam logic [POS_W-1:0] NAME_TAIL     = POS_W'(6);

    localparam int OUT_TDATA_W = 80;

    typedef enum logic [1:0] {
        KIND_NAME   = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_VERSION   = 3'd1,
        ERR_RESERVED  = 3'd2,
        ERR_ADDR_TYPE = 3'd3,
        ERR_LENGTH    = 3'd4
    } err_t;

    // One classified input byte as it sits in the queue
    typedef struct packed {
        logic [7:0] data_byte;
        logic       eom;
        logic       is_version;
        logic       is_reserved;
        logic       is_ipv4;
        logic       is_name;
    } item_t;

    // One result item
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  domain_byte;
        logic [7:0]  command;
        logic        address_kind;
        logic [31:0] ipv4_address;
        logic [15:0] dest_port;
        logic [7:0]  name_length;
        err_t        error_code;
    } result_t;

endpackage

// ===== src/s5req_front.sv =====
module s5req_front
(
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,
    input  logic                s_axis_tlast,
    input  logic                queue_full,
    output logic                push,
    output s5req_pkg::item_t    item
);

    assign s_axis_tready = !queue_full;
    assign push          = s_axis_tvalid && !queue_full;

    // Position-independent byte classification, done once on entry
    always_comb
    begin
        item.data_byte   = s_axis_tdata;
        item.eom         = s_axis_tlast;
        item.is_version  = (s_axis_tdata == s5req_pkg::SOCKS_VERSION);
        item.is_reserved = (s_axis_tdata == s5req_pkg::RESERVED_BYTE);
        item.is_ipv4     = (s_axis_tdata == s5req_pkg::ATYP_IPV4);
        item.is_name     = (s_axis_tdata == s5req_pkg::ATYP_NAME);
    end

endmodule

// ===== src/s5req_queue.sv =====
module s5req_queue
#(
    parameter int DEPTH = s5req_pkg::QUEUE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  s5req_pkg::item_t    push_item,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output s5req_pkg::item_t    head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    s5req_pkg::item_t mem_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== src/s5req_back.sv =====
module s5req_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  s5req_pkg::item_t    head_item,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output s5req_pkg::result_t  out_result
);

    localparam int PW = s5req_pkg::POS_W;

    logic [PW-1:0] pos_reg, pos_next;
    logic          swallow_reg, swallow_next;
    logic [7:0]    cmd_reg, cmd_next;
    logic          akind_reg, akind_next;
    logic [31:0]   ipv4_reg, ipv4_next;
    logic [15:0]   port_reg, port_next;
    logic [7:0]    nlen_reg, nlen_next;

    logic                out_valid_reg, out_valid_next;
    s5req_pkg::result_t  out_result_reg, out_result_next;

    logic                fire;
    logic                has_result;
    s5req_pkg::result_t  result;
    s5req_pkg::err_t     err;
    logic                name_byte;
    logic                akind_eff;
    logic [7:0]          nlen_eff;
    logic [7:0]          cmd_upd;
    logic [31:0]         ipv4_upd;
    logic [15:0]         port_upd;
    logic [PW-1:0]       last_pos;
    logic [PW-1:0]       name_end_pos;
    logic [7:0]          b;
    logic                eom;

    assign fire       = head_valid && (!out_valid_reg || out_ready);
    assign pop        = fire;
    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;
    assign b          = head_item.data_byte;
    assign eom        = head_item.eom;

    assign name_end_pos = s5req_pkg::POS_ADDR + PW'(nlen_reg);

    // Field decode by position
    always_comb
    begin
        err       = s5req_pkg::ERR_NONE;
        name_byte = 1'b0;
        akind_eff = akind_reg;
        nlen_eff  = nlen_reg;
        cmd_upd   = cmd_reg;
        ipv4_upd  = ipv4_reg;
        port_upd  = port_reg;
        if (pos_reg == s5req_pkg::POS_VERSION)
        begin
            if (!head_item.is_version)
            begin
                err = s5req_pkg::ERR_VERSION;
            end
        end
        else if (pos_reg == s5req_pkg::POS_COMMAND)
        begin
            cmd_upd = b;
        end
        else if (pos_reg == s5req_pkg::POS_RESERVED)
        begin
            if (!head_item.is_reserved)
            begin
                err = s5req_pkg::ERR_RESERVED;
            end
        end
        else if (pos_reg == s5req_pkg::POS_ATYP)
        begin
            if (head_item.is_ipv4)
            begin
                akind_eff = 1'b0;
            end
            else if (head_item.is_name)
            begin
                akind_eff = 1'b1;
            end
            else
            begin
                err = s5req_pkg::ERR_ADDR_TYPE;
            end
        end
        else if (!akind_reg)
        begin
            if (pos_reg <= s5req_pkg::POS_IPV4_END)
            begin
                ipv4_upd = {ipv4_reg[23:0], b};
            end
            else
            begin
                port_upd = {port_reg[7:0], b};
            end
        end
        else
        begin
            if (pos_reg == s5req_pkg::POS_ADDR)
            begin
                nlen_eff = b;
            end
            else if (pos_reg <= name_end_pos)
            begin
                name_byte = 1'b1;
            end
            else
            begin
                port_upd = {port_reg[7:0], b};
            end
        end

        last_pos = akind_eff ? (PW'(nlen_eff) + s5req_pkg::NAME_TAIL)
                             : s5req_pkg::POS_IPV4_LAST;

        // Length check: early end, or expected last byte without the end mark
        if (err == s5req_pkg::ERR_NONE)
        begin
            if (eom && ((pos_reg < s5req_pkg::POS_ADDR) || (pos_reg != last_pos)))
            begin
                err = s5req_pkg::ERR_LENGTH;
            end
            else if (!eom && (pos_reg >= s5req_pkg::POS_ADDR) && (pos_reg == last_pos))
            begin
                err = s5req_pkg::ERR_LENGTH;
            end
        end
    end

    // Next state and result
    always_comb
    begin
        pos_next     = pos_reg;
        swallow_next = swallow_reg;
        cmd_next     = cmd_reg;
        akind_next   = akind_reg;
        ipv4_next    = ipv4_reg;
        port_next    = port_reg;
        nlen_next    = nlen_reg;
        has_result   = 1'b0;
        result       = '0;

        if (fire)
        begin
            if (swallow_reg)
            begin
                if (eom)
                begin
                    pos_next     = '0;
                    swallow_next = 1'b0;
                    cmd_next     = '0;
                    akind_next   = 1'b0;
                    ipv4_next    = '0;
                    port_next    = '0;
                    nlen_next    = '0;
                end
            end
            else if (err != s5req_pkg::ERR_NONE)
            begin
                has_result        = 1'b1;
                result.kind       = s5req_pkg::KIND_REJECT;
                result.error_code = err;
                if (eom)
                begin
                    pos_next   = '0;
                    cmd_next   = '0;
                    akind_next = 1'b0;
                    ipv4_next  = '0;
                    port_next  = '0;
                    nlen_next  = '0;
                end
                else
                begin
                    swallow_next = 1'b1;
                end
            end
            else if (eom)
            begin
                has_result          = 1'b1;
                result.kind         = s5req_pkg::KIND_ACCEPT;
                result.command      = cmd_upd;
                result.address_kind = akind_eff;
                result.ipv4_address = akind_eff ? 32'd0 : ipv4_upd;
                result.dest_port    = port_upd;
                result.name_length  = akind_eff ? nlen_eff : 8'd0;
                pos_next   = '0;
                cmd_next   = '0;
                akind_next = 1'b0;
                ipv4_next  = '0;
                port_next  = '0;
                nlen_next  = '0;
            end
            else
            begin
                pos_next   = pos_reg + 1'b1;
                cmd_next   = cmd_upd;
                akind_next = akind_eff;
                ipv4_next  = ipv4_upd;
                port_next  = port_upd;
                nlen_next  = nlen_eff;
                if (name_byte)
                begin
                    has_result         = 1'b1;
                    result.kind        = s5req_pkg::KIND_NAME;
                    result.domain_byte = b;
                end
            end
        end

        out_valid_next  = out_valid_reg;
        out_result_next = out_result_reg;
        if (fire && has_result)
        begin
            out_valid_next  = 1'b1;
            out_result_next = result;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            swallow_reg   <= 1'b0;
            cmd_reg       <= '0;
            akind_reg     <= 1'b0;
            ipv4_reg      <= '0;
            port_reg      <= '0;
            nlen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            swallow_reg   <= swallow_next;
            cmd_reg       <= cmd_next;
            akind_reg     <= akind_next;
            ipv4_reg      <= ipv4_next;
            port_reg      <= port_next;
            nlen_reg      <= nlen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_result_reg <= out_result_next;
    end

    // A byte that yields a result shows up on the output the next cycle
    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        fire && has_result |=> out_valid_reg)
        else $error("result lost on its way to the output register");

    // Swallowed bytes never produce output
    a_swallow_silent: assert property (@(posedge clk) disable iff (!rst_n)
        fire && swallow_reg |-> !has_result)
        else $error("result produced while swallowing");

    // End of message always returns the parser to the version byte
    a_eom_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        fire && eom |=> (pos_reg == '0) && !swallow_reg)
        else $error("parser not restarted after end of message");

    // A reject always carries a code, nothing else does
    a_reject_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            ((out_result_reg.kind == s5req_pkg::KIND_REJECT) ==
             (out_result_reg.error_code != s5req_pkg::ERR_NONE)))
        else $error("error code does not match result kind");

    // Position never runs past the longest legal request
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= (PW'(8'hFF) + s5req_pkg::NAME_TAIL))
        else $error("byte position out of range");

endmodule

// ===== src/socks5_connect_request_parser.sv =====
// SOCKS5 connect request parser.
// Input stream (s_axis): one request byte per transfer; tlast marks the final
// byte of a request. Output stream (m_axis): tuser carries the result kind
// (name byte, request accepted, request rejected), tdata the result fields.
// Every name byte of a domain request comes out as it arrives; the last byte
// of a request brings an accept carrying command, address and port, or the
// first error brings one reject, after which bytes are dropped up to tlast.
// Throughput: one byte per cycle sustained while m_axis_tready stays high, set
// by the parser's position decode. A byte's transfer writes it into the byte
// queue; any result it yields is then written into the output register. A small
// queue decouples the classifier from the parser, so s_axis_tready depends only
// on queue fill, never on m_axis_tready directly.
// Receiver stall: the output register holds its result, the parser stops,
// the queue fills and s_axis_tready falls; nothing is dropped.
// Reset (rst_n low, asynchronous): queue emptied, output invalid, parser
// waits for a version byte.
module socks5_connect_request_parser
#(
    parameter int QUEUE_DEPTH = s5req_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // end_of_message

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] domain_byte, [15:8] command, [16] address_kind,
    // [48:17] ipv4_address, [64:49] dest_port, [72:65] name_length,
    // [75:73] error_code, [79:76] zero
    output logic [s5req_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser    // [1:0] kind
);

    logic                queue_full;
    logic                push;
    s5req_pkg::item_t    push_item;
    logic                pop;
    logic                head_valid;
    s5req_pkg::item_t    head_item;
    s5req_pkg::result_t  result;

    // Front: accept and classify bytes
    s5req_front u_front
    (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .queue_full    (queue_full),
        .push          (push),
        .item          (push_item)
    );

    // Short queue between classifier and parser
    s5req_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // Back: position decode, field capture, checks, output register
    s5req_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    assign m_axis_tuser = result.kind;
    assign m_axis_tdata = {4'b0000,
                           result.error_code,
                           result.name_length,
                           result.dest_port,
                           result.ipv4_address,
                           result.address_kind,
                           result.command,
                           result.domain_byte};

endmodule
